// File: design/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg: shared types and constants for the calendar seconds converter
// Command and status structs between controller and datapath, month tables,
// division and multiplier constants.
// ----------------------------------------------------------------------------
package csc_pkg;

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;
   localparam logic [31:0] SECS_PER_YEAR = 32'd31536000;
   localparam logic [31:0] BASE_YEAR     = 32'd2000;
   localparam logic [31:0] LEAP_REF_YEAR = 32'd1997;
   localparam logic [8:0]  DAYS_COMMON   = 9'd365;
   localparam logic [8:0]  DAYS_LEAP     = 9'd366;

   // reciprocals: days = (e >> 7) * RECIP_DAY >> 35, hour = (r >> 4) * RECIP_HOUR >> 20,
   // minute = (r >> 2) * RECIP_MIN >> 14, exact over each operand range
   localparam logic [25:0] RECIP_DAY  = 26'd50903317;
   localparam logic [25:0] RECIP_HOUR = 26'd4661;
   localparam logic [25:0] RECIP_MIN  = 26'd1093;

   // division steps, each quotient followed by its remainder update
   localparam logic [2:0] DIV_DAYS     = 3'd0;
   localparam logic [2:0] DIV_DAY_REM  = 3'd1;
   localparam logic [2:0] DIV_HOUR     = 3'd2;
   localparam logic [2:0] DIV_HOUR_REM = 3'd3;
   localparam logic [2:0] DIV_MIN      = 3'd4;
   localparam logic [2:0] DIV_MIN_REM  = 3'd5;
   localparam logic [3:0] DIV_LAST     = 4'd5;

   // multiply-accumulate terms, an extra step drains the product register
   localparam logic [2:0] TERM_DAYS   = 3'd0;
   localparam logic [2:0] TERM_YEARS  = 3'd1;
   localparam logic [2:0] TERM_HOUR   = 3'd2;
   localparam logic [2:0] TERM_MINUTE = 3'd3;
   localparam logic [2:0] TERM_SECOND = 3'd4;
   localparam logic [3:0] MUL_LAST    = 4'd5;

   localparam logic [3:0] LAST_MONTH = 4'd11;
   localparam logic [3:0] FEB_INDEX  = 4'd1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_MUL,
      OP_DIV_STEP,
      OP_YEAR_STEP,
      OP_MONTH_STEP,
      OP_LOAD_OUT
   } csc_op_type;

   typedef struct packed {
      csc_op_type op;
      logic [2:0] sel;
   } csc_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } csc_sts_type;

   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] r;
      case (idx)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd59;
         4'd3:    r = 9'd90;
         4'd4:    r = 9'd120;
         4'd5:    r = 9'd151;
         4'd6:    r = 9'd181;
         4'd7:    r = 9'd212;
         4'd8:    r = 9'd243;
         4'd9:    r = 9'd273;
         4'd10:   r = 9'd304;
         default: r = 9'd334;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] idx);
      logic [4:0] r;
      case (idx)
         4'd1:    r = 5'd28;
         4'd3:    r = 5'd30;
         4'd5:    r = 5'd30;
         4'd8:    r = 5'd30;
         4'd10:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// File: design/csc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_ctrl: conversion sequencer
// Accepts items, steps the datapath through multiply, divide, year and month
// phases, and owns the result valid flag.
// ----------------------------------------------------------------------------
module csc_ctrl
   import csc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_func,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  csc_sts_type sts,
   output csc_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_YEAR  = 6'b001000,
      ST_MONTH = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.sel      = cnt_ff[2:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_START;
               cnt_in = '0;
               if (req_func) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            cmd.op = OP_MUL;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            cmd.op = OP_YEAR_STEP;
            if (sts.year_done) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.op = OP_MONTH_STEP;
            if (sts.month_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_LOAD_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/csc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_dp: conversion datapath
// Multiply-accumulate for date to seconds, reciprocal-multiply division,
// year and month walkers for seconds to date, and the result register.
// ----------------------------------------------------------------------------
module csc_dp
   import csc_pkg::*;
(
   input  logic        clock,
   input  csc_cmd_type cmd,
   output csc_sts_type sts,
   input  logic        req_func,
   input  logic [31:0] req_elapsed_in,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic [31:0] rsp_elapsed_out,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out
);

   logic        func_ff;
   logic [31:0] daysum_ff, yd_ff, rem_ff, acc_ff, prod_ff;
   logic [15:0] days_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [7:0]  year_ff;
   logic [3:0]  mon_ff;

   logic [31:0] elapsed_ff;
   logic [11:0] year_out_ff;
   logic [3:0]  month_out_ff;
   logic [4:0]  day_out_ff, hour_out_ff;
   logic [5:0]  minute_out_ff, second_out_ff;

   // date-side operand preparation at accept time
   logic [3:0]  mon_idx;
   logic [31:0] year_ext, yd_in, leaps, daysum_in;
   logic        leap_add;

   always_comb begin
      if (req_month_in == 4'd0) begin
         mon_idx = 4'd0;
      end else if (req_month_in > 4'd12) begin
         mon_idx = LAST_MONTH;
      end else begin
         mon_idx = req_month_in - 4'd1;
      end
      year_ext  = {20'd0, req_year_in};
      yd_in     = year_ext - BASE_YEAR;
      leaps     = (year_ext - LEAP_REF_YEAR) >> 2;
      leap_add  = (req_year_in[1:0] == 2'd0) && (mon_idx >= 4'd2);
      daysum_in = 32'(month_start(mon_idx)) + 32'(req_day_in) - 32'd1 + leaps
                  + 32'(leap_add);
   end

   // one multiplier, term chosen by the sequencer
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_full;

   always_comb begin
      case (cmd.sel)
         TERM_DAYS: begin
            mul_a = daysum_ff;
            mul_b = SECS_PER_DAY;
         end
         TERM_YEARS: begin
            mul_a = yd_ff;
            mul_b = SECS_PER_YEAR;
         end
         TERM_HOUR: begin
            mul_a = 32'(hour_ff);
            mul_b = SECS_PER_HOUR;
         end
         TERM_MINUTE: begin
            mul_a = 32'(minute_ff);
            mul_b = SECS_PER_MIN;
         end
         TERM_SECOND: begin
            mul_a = rem_ff;
            mul_b = 32'd1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = 64'(mul_a) * 64'(mul_b);
   end

   // division multiplier: quotient by reciprocal, then remainder by product
   logic [25:0] div_a, div_b;
   logic [51:0] div_p;

   always_comb begin
      case (cmd.sel)
         DIV_DAYS: begin
            div_a = 26'(rem_ff[31:7]);
            div_b = RECIP_DAY;
         end
         DIV_DAY_REM: begin
            div_a = 26'(days_ff);
            div_b = SECS_PER_DAY[25:0];
         end
         DIV_HOUR: begin
            div_a = 26'(rem_ff[16:4]);
            div_b = RECIP_HOUR;
         end
         DIV_HOUR_REM: begin
            div_a = 26'(hour_ff);
            div_b = SECS_PER_HOUR[25:0];
         end
         DIV_MIN: begin
            div_a = 26'(rem_ff[11:2]);
            div_b = RECIP_MIN;
         end
         DIV_MIN_REM: begin
            div_a = 26'(minute_ff);
            div_b = SECS_PER_MIN[25:0];
         end
         default: begin
            div_a = '0;
            div_b = '0;
         end
      endcase
      div_p = 52'(div_a) * 52'(div_b);
   end

   // year and month step logic
   logic [8:0] ylen;
   logic [4:0] mlen;

   assign ylen   = (year_ff[1:0] == 2'd0) ? DAYS_LEAP : DAYS_COMMON;
   assign mlen   = month_len(mon_ff)
                   + {4'd0, (mon_ff == FEB_INDEX) && (year_ff[1:0] == 2'd0)};

   assign sts.year_done  = days_ff < 16'(ylen);
   assign sts.month_done = (mon_ff == LAST_MONTH) || (days_ff < 16'(mlen));

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            func_ff   <= req_func;
            hour_ff   <= req_hour_in;
            minute_ff <= req_minute_in;
            rem_ff    <= req_func ? req_elapsed_in : 32'(req_second_in);
            daysum_ff <= daysum_in;
            yd_ff     <= yd_in;
            acc_ff    <= '0;
            prod_ff   <= '0;
            year_ff   <= '0;
            mon_ff    <= '0;
         end
         OP_MUL: begin
            prod_ff <= mul_full[31:0];
            acc_ff  <= acc_ff + prod_ff;
         end
         OP_DIV_STEP: begin
            case (cmd.sel)
               DIV_DAYS: begin
                  days_ff <= div_p[50:35];
               end
               DIV_HOUR: begin
                  hour_ff <= div_p[24:20];
               end
               DIV_MIN: begin
                  minute_ff <= div_p[19:14];
               end
               default: begin
                  rem_ff <= rem_ff - div_p[31:0];
               end
            endcase
         end
         OP_YEAR_STEP: begin
            if (!sts.year_done) begin
               year_ff <= year_ff + 8'd1;
               days_ff <= days_ff - 16'(ylen);
            end
         end
         OP_MONTH_STEP: begin
            if (!sts.month_done) begin
               mon_ff  <= mon_ff + 4'd1;
               days_ff <= days_ff - 16'(mlen);
            end
         end
         OP_LOAD_OUT: begin
            if (func_ff) begin
               elapsed_ff    <= '0;
               year_out_ff   <= 12'(year_ff) + BASE_YEAR[11:0];
               month_out_ff  <= mon_ff + 4'd1;
               day_out_ff    <= days_ff[4:0] + 5'd1;
               hour_out_ff   <= hour_ff;
               minute_out_ff <= minute_ff;
               second_out_ff <= rem_ff[5:0];
            end else begin
               elapsed_ff    <= acc_ff;
               year_out_ff   <= '0;
               month_out_ff  <= '0;
               day_out_ff    <= '0;
               hour_out_ff   <= '0;
               minute_out_ff <= '0;
               second_out_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_elapsed_out = elapsed_ff;
   assign rsp_year_out    = year_out_ff;
   assign rsp_month_out   = month_out_ff;
   assign rsp_day_out     = day_out_ff;
   assign rsp_hour_out    = hour_out_ff;
   assign rsp_minute_out  = minute_out_ff;
   assign rsp_second_out  = second_out_ff;

endmodule

// File: design/calendar_seconds_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_seconds_converter: calendar date-time <-> seconds since 2000-01-01
// Sequencer plus datapath; one result item for each input item.
//
//   channel  ports   direction  handshake
//   request  req_*   in         req_valid / req_ready
//   response rsp_*   out        rsp_valid / rsp_ready
//
// date to seconds: five multiply-accumulate terms on one 32x32 multiplier
// plus a drain step. seconds to date: six reciprocal-multiply and subtract
// steps split off days, hour, minute and second, then one step per year
// walked (up to 136) and per month walked (up to 11). one item is
// converted at a time; the next is taken while the last result waits in
// the output register.
// reset clears the sequencer and the result valid flag.
// ----------------------------------------------------------------------------
module calendar_seconds_converter
   import csc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_elapsed_in,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_elapsed_out,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out
);

   csc_cmd_type cmd;
   csc_sts_type sts;

   csc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   csc_dp u_dp (
      .clock           (clock),
      .cmd             (cmd),
      .sts             (sts),
      .req_func        (req_func),
      .req_elapsed_in  (req_elapsed_in),
      .req_year_in     (req_year_in),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_hour_in     (req_hour_in),
      .req_minute_in   (req_minute_in),
      .req_second_in   (req_second_in),
      .rsp_elapsed_out (rsp_elapsed_out),
      .rsp_year_out    (rsp_year_out),
      .rsp_month_out   (rsp_month_out),
      .rsp_day_out     (rsp_day_out),
      .rsp_hour_out    (rsp_hour_out),
      .rsp_minute_out  (rsp_minute_out),
      .rsp_second_out  (rsp_second_out)
   );

endmodule
